// ----- hw/rtl/byte_budget_lru_cache_top_defines.svh -----
// assertion macros used by the cache back end
// no dependencies
`ifndef BYTE_BUDGET_LRU_CACHE_TOP_DEFINES_SVH
`define BYTE_BUDGET_LRU_CACHE_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BBC_ASSERT_NOW(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("bbc assertion failed");

// next-cycle implication, checked outside reset
`define BBC_ASSERT_NEXT(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("bbc assertion failed");

`endif

// ----- hw/rtl/bbc_pkg.sv -----
// shared types and constants of the byte budget lru cache
// no dependencies
`default_nettype none
package bbc_pkg;
	localparam int BBC_ENTRIES      = 16;
	localparam int BBC_COUNTER_BITS = 32;
	localparam int QDEPTH           = 2;

	// configuration register indexes
	localparam logic REG_MAX_ENTRIES = 1'b0;
	localparam logic REG_MAX_BYTES   = 1'b1;

	typedef enum logic [1:0] {
		ST_MISS     = 2'd0,
		ST_HIT      = 2'd1,
		ST_INSERTED = 2'd2,
		ST_OVER     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MATCH,
		S_DECIDE,
		S_CHECK,
		S_EVICT,
		S_WRITE,
		S_DONE
	} back_state_t;

	typedef struct packed {
		logic         action;
		logic         over;
		logic [255:0] key;
		logic [31:0]  payload;
		logic [47:0]  bytes;
	} item_t;

	typedef struct packed {
		logic  avail;
		item_t item;
	} queue_head_t;
endpackage
`default_nettype wire

// ----- hw/rtl/byte_budget_lru_cache_top.sv -----
// top level of the byte budget lru cache: config registers, front and back
// depends on bbc_pkg, bbc_front, bbc_back
`default_nettype none
// usage
//   input words: raise start with action, key words, payload and entry_bytes;
//   a word is taken at a clock edge where start is high and busy is low.
//   busy rises once two words wait in the queue between front and back.
//   results: done is high for exactly one cycle with status, found_payload,
//   evicted_count, entry_count, bytes_held and the four saturating totals;
//   the receiver must take it then, it cannot hold results off.
//   config: cfg_we with cfg_index 0 (max_entries) or 1 (max_bytes) and
//   cfg_wdata writes at once; write only while no word is in flight.
// operation
//   every word makes one scan of the slots for its key, one slot read per
//   cycle; a lookup passes the idle, scan, decide and done states, and the
//   back end takes the next word from the queue only once back in idle.
//   an insert adds the check and write states, plus a budget check and a
//   victim scan per evicted entry; the slot read port sets this pace.
// reset
//   arst_n clears all slots, the byte sum, the stamp and every total, and
//   restores max_entries and max_bytes to their full values.
module byte_budget_lru_cache_top import bbc_pkg::*; #(
	parameter int ENTRIES      = BBC_ENTRIES,
	parameter int COUNTER_BITS = BBC_COUNTER_BITS,
	localparam int CNT_W = $clog2(ENTRIES + 1)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               action,
	input  wire logic [63:0]        key_word_0,
	input  wire logic [63:0]        key_word_1,
	input  wire logic [63:0]        key_word_2,
	input  wire logic [63:0]        key_word_3,
	input  wire logic [31:0]        payload,
	input  wire logic [47:0]        entry_bytes,
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [47:0]        cfg_wdata,
	output logic                    done,
	output logic [1:0]              status,
	output logic [31:0]             found_payload,
	output logic [CNT_W-1:0]        evicted_count,
	output logic [CNT_W-1:0]        entry_count,
	output logic [47:0]             bytes_held,
	output logic [COUNTER_BITS-1:0] lookup_total,
	output logic [COUNTER_BITS-1:0] hit_total,
	output logic [COUNTER_BITS-1:0] miss_total,
	output logic [COUNTER_BITS-1:0] eviction_total
);
	// config registers, full budget after reset
	logic [4:0]  max_entries_q;
	logic [47:0] max_bytes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_entries_q <= 5'd16;
			max_bytes_q   <= '1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_ENTRIES: max_entries_q <= cfg_wdata[4:0];
				REG_MAX_BYTES:   max_bytes_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// front queue head and pop between the two halves
	queue_head_t head;
	logic        pop;

	bbc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.action      (action),
		.key_word_0  (key_word_0),
		.key_word_1  (key_word_1),
		.key_word_2  (key_word_2),
		.key_word_3  (key_word_3),
		.payload     (payload),
		.entry_bytes (entry_bytes),
		.max_entries (max_entries_q),
		.max_bytes   (max_bytes_q),
		.pop         (pop),
		.head        (head)
	);

	bbc_back #(
		.ENTRIES      (ENTRIES),
		.COUNTER_BITS (COUNTER_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.pop            (pop),
		.max_entries    (max_entries_q),
		.max_bytes      (max_bytes_q),
		.done           (done),
		.status         (status),
		.found_payload  (found_payload),
		.evicted_count  (evicted_count),
		.entry_count    (entry_count),
		.bytes_held     (bytes_held),
		.lookup_total   (lookup_total),
		.hit_total      (hit_total),
		.miss_total     (miss_total),
		.eviction_total (eviction_total)
	);
endmodule
`default_nettype wire

// ----- hw/rtl/bbc_front.sv -----
// front end: accepts words, tags over-budget inserts, two-deep queue
// depends on bbc_pkg
`default_nettype none
module bbc_front import bbc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        action,
	input  wire logic [63:0] key_word_0,
	input  wire logic [63:0] key_word_1,
	input  wire logic [63:0] key_word_2,
	input  wire logic [63:0] key_word_3,
	input  wire logic [31:0] payload,
	input  wire logic [47:0] entry_bytes,
	input  wire logic [4:0]  max_entries,
	input  wire logic [47:0] max_bytes,
	input  wire logic        pop,
	output queue_head_t      head
);
	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	item_t         q_mem [QDEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          push, pop_ok;
	item_t         in_item;

	always_comb begin
		in_item.action  = action;
		in_item.over    = action & ((max_entries == 5'd0) | (max_bytes == 48'd0) |
			(entry_bytes > max_bytes));
		in_item.key     = {key_word_0, key_word_1, key_word_2, key_word_3};
		in_item.payload = payload;
		in_item.bytes   = entry_bytes;
	end

	assign busy   = (cnt_q == CW'(QDEPTH));
	assign push   = start & ~busy;
	assign pop_ok = pop & (cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop_ok)
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop_ok)
				cnt_q <= cnt_q + 1'b1;
			else if (!push && pop_ok)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			q_mem[wr_ptr_q] <= in_item;
	end

	assign head.avail = (cnt_q != '0);
	assign head.item  = q_mem[rd_ptr_q];
endmodule
`default_nettype wire

// ----- hw/rtl/bbc_back.sv -----
// back end: slot store, match and victim scans, eviction and insert
// depends on bbc_pkg and byte_budget_lru_cache_top_defines.svh
`default_nettype none
`include "byte_budget_lru_cache_top_defines.svh"
module bbc_back import bbc_pkg::*; #(
	parameter int ENTRIES      = BBC_ENTRIES,
	parameter int COUNTER_BITS = BBC_COUNTER_BITS,
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
	localparam int CNT_W = $clog2(ENTRIES + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire queue_head_t       head,
	output logic                   pop,
	input  wire logic [4:0]        max_entries,
	input  wire logic [47:0]       max_bytes,
	output logic                   done,
	output logic [1:0]             status,
	output logic [31:0]            found_payload,
	output logic [CNT_W-1:0]       evicted_count,
	output logic [CNT_W-1:0]       entry_count,
	output logic [47:0]            bytes_held,
	output logic [COUNTER_BITS-1:0] lookup_total,
	output logic [COUNTER_BITS-1:0] hit_total,
	output logic [COUNTER_BITS-1:0] miss_total,
	output logic [COUNTER_BITS-1:0] eviction_total
);
	localparam int SCW = IDX_W + 1;

	back_state_t state_q, state_d;

	logic [255:0] key_mem   [ENTRIES];
	logic [31:0]  pay_mem   [ENTRIES];
	logic [47:0]  size_mem  [ENTRIES];
	logic [63:0]  stamp_mem [ENTRIES];
	logic [ENTRIES-1:0] valid_q;

	logic [255:0] key_rd_s1;
	logic [31:0]  pay_rd_s1;
	logic [47:0]  size_rd_s1;
	logic [63:0]  stamp_rd_s1;
	logic             chk_v_s1;
	logic [IDX_W-1:0] chk_idx_s1;

	item_t            cur_q;
	logic [SCW-1:0]   scan_cnt_q;
	logic             hit_q, free_v_q, vic_v_q;
	logic [IDX_W-1:0] hit_idx_q, free_idx_q, vic_idx_q;
	logic [31:0]      hit_pay_q;
	logic [63:0]      vic_stamp_q;
	logic [47:0]      vic_size_q;
	logic [63:0]      stamp_q;
	logic [47:0]      byte_sum_q;
	logic [CNT_W-1:0] occ_q, evicted_q, limit;
	logic [1:0]       status_q;
	logic [31:0]      found_q;
	logic [COUNTER_BITS-1:0] lookup_q, hit_cnt_q, miss_q, evict_cnt_q;

	logic scanning, scan_issue, scan_done, need_evict, finish_now;
	logic [IDX_W-1:0] rd_addr;
	logic             stamp_we;
	logic [IDX_W-1:0] stamp_wa;

	// entry limit above capacity acts as capacity
	assign limit = (int'(max_entries) > ENTRIES) ? CNT_W'(ENTRIES) : CNT_W'(max_entries);
	assign need_evict = (occ_q != '0) &&
		((occ_q >= limit) || (byte_sum_q > (max_bytes - cur_q.bytes)));
	assign finish_now = hit_q | ~cur_q.action | cur_q.over;

	// control outputs
	always_comb begin
		scanning   = (state_q == S_MATCH) || (state_q == S_EVICT);
		scan_issue = scanning && (scan_cnt_q < SCW'(ENTRIES));
		scan_done  = scanning && (scan_cnt_q == SCW'(ENTRIES)) && !chk_v_s1;
		pop        = (state_q == S_IDLE) && head.avail;
		done       = (state_q == S_DONE);
		rd_addr    = scan_cnt_q[IDX_W-1:0];
		stamp_we   = ((state_q == S_DECIDE) && hit_q) || ((state_q == S_WRITE) && free_v_q);
		stamp_wa   = (state_q == S_WRITE) ? free_idx_q : hit_idx_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (head.avail) state_d = S_MATCH;
			S_MATCH:  if (scan_done) state_d = S_DECIDE;
			S_DECIDE: state_d = finish_now ? S_DONE : S_CHECK;
			S_CHECK:  state_d = need_evict ? S_EVICT : S_WRITE;
			S_EVICT:  if (scan_done) state_d = S_CHECK;
			S_WRITE:  state_d = S_DONE;
			S_DONE:   state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			chk_v_s1    <= 1'b0;
			scan_cnt_q  <= '0;
			hit_q       <= 1'b0;
			free_v_q    <= 1'b0;
			vic_v_q     <= 1'b0;
			stamp_q     <= '0;
			byte_sum_q  <= '0;
			occ_q       <= '0;
			evicted_q   <= '0;
			lookup_q    <= '0;
			hit_cnt_q   <= '0;
			miss_q      <= '0;
			evict_cnt_q <= '0;
		end else begin
			state_q  <= state_d;
			chk_v_s1 <= scan_issue;
			if (scan_issue)
				scan_cnt_q <= scan_cnt_q + 1'b1;
			case (state_q)
				S_IDLE: begin
					scan_cnt_q <= '0;
					hit_q      <= 1'b0;
					free_v_q   <= 1'b0;
					evicted_q  <= '0;
				end
				S_MATCH: begin
					if (chk_v_s1) begin
						if (valid_q[chk_idx_s1] && key_rd_s1 == cur_q.key && !hit_q) begin
							hit_q     <= 1'b1;
							hit_idx_q <= chk_idx_s1;
						end
						if (!valid_q[chk_idx_s1] && !free_v_q) begin
							free_v_q   <= 1'b1;
							free_idx_q <= chk_idx_s1;
						end
					end
				end
				S_DECIDE: begin
					if (!cur_q.action)
						lookup_q <= (lookup_q == '1) ? lookup_q : lookup_q + 1'b1;
					if (hit_q) begin
						stamp_q   <= stamp_q + 64'd1;
						hit_cnt_q <= (hit_cnt_q == '1) ? hit_cnt_q : hit_cnt_q + 1'b1;
					end else if (!cur_q.action) begin
						miss_q <= (miss_q == '1) ? miss_q : miss_q + 1'b1;
					end
				end
				S_CHECK: begin
					scan_cnt_q <= '0;
					vic_v_q    <= 1'b0;
				end
				S_EVICT: begin
					if (chk_v_s1 && valid_q[chk_idx_s1] &&
						(!vic_v_q || stamp_rd_s1 < vic_stamp_q))
						vic_v_q <= 1'b1;
					if (scan_done && vic_v_q) begin
						valid_q[vic_idx_q] <= 1'b0;
						byte_sum_q  <= byte_sum_q - vic_size_q;
						occ_q       <= occ_q - 1'b1;
						evicted_q   <= evicted_q + 1'b1;
						evict_cnt_q <= (evict_cnt_q == '1) ? evict_cnt_q : evict_cnt_q + 1'b1;
						if (!free_v_q || vic_idx_q < free_idx_q) begin
							free_v_q   <= 1'b1;
							free_idx_q <= vic_idx_q;
						end
					end
				end
				S_WRITE: begin
					if (free_v_q) begin
						valid_q[free_idx_q] <= 1'b1;
						stamp_q    <= stamp_q + 64'd1;
						byte_sum_q <= byte_sum_q + cur_q.bytes;
						occ_q      <= occ_q + 1'b1;
					end
				end
				S_DONE: ;
				default: ;
			endcase
		end
	end

	// payload registers and slot memories
	always_ff @(posedge clk) begin
		key_rd_s1   <= key_mem[rd_addr];
		pay_rd_s1   <= pay_mem[rd_addr];
		size_rd_s1  <= size_mem[rd_addr];
		stamp_rd_s1 <= stamp_mem[rd_addr];
		chk_idx_s1  <= rd_addr;
		if (pop)
			cur_q <= head.item;
		if (state_q == S_MATCH && chk_v_s1 && valid_q[chk_idx_s1] &&
			key_rd_s1 == cur_q.key && !hit_q)
			hit_pay_q <= pay_rd_s1;
		if (state_q == S_EVICT && chk_v_s1 && valid_q[chk_idx_s1] &&
			(!vic_v_q || stamp_rd_s1 < vic_stamp_q)) begin
			vic_idx_q   <= chk_idx_s1;
			vic_stamp_q <= stamp_rd_s1;
			vic_size_q  <= size_rd_s1;
		end
		if (stamp_we)
			stamp_mem[stamp_wa] <= stamp_q + 64'd1;
		if (state_q == S_WRITE && free_v_q) begin
			key_mem[free_idx_q]  <= cur_q.key;
			pay_mem[free_idx_q]  <= cur_q.payload;
			size_mem[free_idx_q] <= cur_q.bytes;
		end
		if (state_q == S_DECIDE) begin
			if (hit_q) begin
				status_q <= ST_HIT;
				found_q  <= hit_pay_q;
			end else if (!cur_q.action) begin
				status_q <= ST_MISS;
				found_q  <= '0;
			end else if (cur_q.over) begin
				status_q <= ST_OVER;
				found_q  <= '0;
			end
		end
		if (state_q == S_WRITE) begin
			status_q <= ST_INSERTED;
			found_q  <= cur_q.payload;
		end
	end

	assign status         = status_q;
	assign found_payload  = found_q;
	assign evicted_count  = evicted_q;
	assign entry_count    = occ_q;
	assign bytes_held     = byte_sum_q;
	assign lookup_total   = lookup_q;
	assign hit_total      = hit_cnt_q;
	assign miss_total     = miss_q;
	assign eviction_total = evict_cnt_q;

	`BBC_ASSERT_NOW(a_occ_cap, clk, arst_n, 1'b1, occ_q <= CNT_W'(ENTRIES))
	`BBC_ASSERT_NEXT(a_done_idle, clk, arst_n, state_q == S_DONE, state_q == S_IDLE)
	`BBC_ASSERT_NOW(a_victim_found, clk, arst_n, (state_q == S_EVICT) && scan_done, vic_v_q)
	`BBC_ASSERT_NOW(a_pop_idle, clk, arst_n, pop, (state_q == S_IDLE) && head.avail)
endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
// self-checking testbench for the byte budget lru cache
// depends on bbc_pkg and byte_budget_lru_cache_top; predicts each result in a scoreboard class
`default_nettype none
module tb_top import bbc_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [47:0] BYTES_FULL = '1;
	localparam int WATCHDOG_LIMIT = 4000;

	// one input word as the cache sees it
	typedef struct {
		logic         action;
		logic [255:0] key;
		logic [31:0]  payload;
		logic [47:0]  bytes;
	} cache_word_t;

	// one result word
	typedef struct {
		status_t     status;
		logic [31:0] found;
		logic [4:0]  evicted;
		logic [4:0]  entries;
		logic [47:0] bytes;
		logic [31:0] lookups;
		logic [31:0] hits;
		logic [31:0] misses;
		logic [31:0] evictions;
	} cache_result_t;

	// lru cache predictor plus the queue of predicted results
	class cache_scoreboard;
		logic         valid [BBC_ENTRIES];
		logic [255:0] keys [BBC_ENTRIES];
		logic [31:0]  handles [BBC_ENTRIES];
		logic [47:0]  sizes [BBC_ENTRIES];
		logic [63:0]  stamps [BBC_ENTRIES];
		logic [63:0]  stamp_now;
		logic [47:0]  byte_sum;
		int           occupancy;
		logic [31:0]  n_lookup, n_hit, n_miss, n_evict;
		logic [4:0]   entry_limit;
		logic [47:0]  byte_limit;
		cache_result_t pending[$];
		int           errors;

		function new();
			foreach (valid[i]) valid[i] = 1'b0;
			stamp_now = '0;
			byte_sum = '0;
			occupancy = 0;
			n_lookup = '0;
			n_hit = '0;
			n_miss = '0;
			n_evict = '0;
			entry_limit = 5'd16;
			byte_limit = BYTES_FULL;
			errors = 0;
		endfunction

		function automatic logic [31:0] bump(logic [31:0] v);
			return (v == '1) ? v : v + 1;
		endfunction

		function automatic void set_reg(logic idx, logic [47:0] value);
			if (idx == REG_MAX_ENTRIES) begin
				entry_limit = value[4:0];
			end else begin
				byte_limit = value;
			end
		endfunction

		// drop the valid slot with the smallest stamp, lowest index on ties
		function automatic void drop_oldest();
			int victim;
			victim = -1;
			for (int i = 0; i < BBC_ENTRIES; i++) begin
				if (valid[i] && (victim < 0 || stamps[i] < stamps[victim])) victim = i;
			end
			if (victim < 0) return;
			valid[victim] = 1'b0;
			byte_sum = byte_sum - sizes[victim];
			if (occupancy > 0) occupancy--;
			n_evict = bump(n_evict);
		endfunction

		function automatic void note_word(cache_word_t w);
			cache_result_t r;
			int hit_slot, free_slot, cap;
			r.found = '0;
			r.evicted = '0;
			hit_slot = -1;
			free_slot = -1;
			if (!w.action) n_lookup = bump(n_lookup);
			for (int i = 0; i < BBC_ENTRIES; i++) begin
				if (hit_slot < 0 && valid[i] && keys[i] == w.key) hit_slot = i;
			end
			if (hit_slot >= 0) begin
				stamp_now++;
				stamps[hit_slot] = stamp_now;
				n_hit = bump(n_hit);
				r.status = ST_HIT;
				r.found = handles[hit_slot];
			end else if (!w.action) begin
				n_miss = bump(n_miss);
				r.status = ST_MISS;
			end else if (entry_limit == 0 || byte_limit == 0 || w.bytes > byte_limit) begin
				r.status = ST_OVER;
			end else begin
				// an entry limit above capacity acts as full capacity
				cap = (entry_limit > BBC_ENTRIES) ? BBC_ENTRIES : entry_limit;
				while (occupancy > 0 &&
						(occupancy >= cap || byte_sum > byte_limit - w.bytes)) begin
					drop_oldest();
					r.evicted++;
				end
				for (int i = 0; i < BBC_ENTRIES; i++) begin
					if (free_slot < 0 && !valid[i]) free_slot = i;
				end
				if (free_slot >= 0) begin
					stamp_now++;
					valid[free_slot] = 1'b1;
					keys[free_slot] = w.key;
					handles[free_slot] = w.payload;
					sizes[free_slot] = w.bytes;
					stamps[free_slot] = stamp_now;
					byte_sum = byte_sum + w.bytes;
					occupancy++;
				end
				r.status = ST_INSERTED;
				r.found = w.payload;
			end
			r.entries = occupancy[4:0];
			r.bytes = byte_sum;
			r.lookups = n_lookup;
			r.hits = n_hit;
			r.misses = n_miss;
			r.evictions = n_evict;
			pending.insert(pending.size(), r);
		endfunction

		function automatic void compare(string field, logic [63:0] exp, logic [63:0] act);
			if (exp !== act) begin
				$error("%s mismatch: expected %0h, got %0h", field, exp, act);
				errors++;
			end
		endfunction

		function automatic void check_result(cache_result_t got);
			cache_result_t exp;
			if (pending.size() == 0) begin
				$error("result word with nothing predicted");
				errors++;
				return;
			end
			exp = pending.pop_front();
			compare("status", exp.status, got.status);
			compare("found_payload", exp.found, got.found);
			compare("evicted_count", exp.evicted, got.evicted);
			compare("entry_count", exp.entries, got.entries);
			compare("bytes_held", exp.bytes, got.bytes);
			compare("lookup_total", exp.lookups, got.lookups);
			compare("hit_total", exp.hits, got.hits);
			compare("miss_total", exp.misses, got.misses);
			compare("eviction_total", exp.evictions, got.evictions);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        action = 1'b0;
	logic [63:0] key_word_0 = '0, key_word_1 = '0, key_word_2 = '0, key_word_3 = '0;
	logic [31:0] payload = '0;
	logic [47:0] entry_bytes = '0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = REG_MAX_ENTRIES;
	logic [47:0] cfg_wdata = '0;
	logic        busy, done;
	logic [1:0]  status;
	logic [31:0] found_payload;
	logic [4:0]  evicted_count, entry_count;
	logic [47:0] bytes_held;
	logic [31:0] lookup_total, hit_total, miss_total, eviction_total;

	cache_scoreboard sb = new();
	logic [255:0] key_pool [24];
	int           accepts = 0;   // input words taken, for the watchdog
	int           idle_pct = 0;

	always #5 clk = ~clk;

	byte_budget_lru_cache_top uut (
		.clk, .arst_n, .start, .busy, .action,
		.key_word_0, .key_word_1, .key_word_2, .key_word_3,
		.payload, .entry_bytes,
		.cfg_we, .cfg_index, .cfg_wdata,
		.done, .status, .found_payload, .evicted_count, .entry_count, .bytes_held,
		.lookup_total, .hit_total, .miss_total, .eviction_total
	);

	// results are sampled mid-cycle, where done and the fields are settled
	always @(negedge clk) begin
		cache_result_t got;
		if (arst_n && done) begin
			got.status = status_t'(status);
			got.found = found_payload;
			got.evicted = evicted_count;
			got.entries = entry_count;
			got.bytes = bytes_held;
			got.lookups = lookup_total;
			got.hits = hit_total;
			got.misses = miss_total;
			got.evictions = eviction_total;
			sb.check_result(got);
		end
	end

	// watchdog: cycles in which neither an input word nor a result word moves
	initial begin
		int quiet, seen;
		quiet = 0;
		seen = 0;
		forever begin
			@(negedge clk);
			if (done || accepts != seen) begin
				quiet = 0;
			end else begin
				quiet++;
			end
			seen = accepts;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// hand one word to the cache; start stays high from word to word unless a gap is drawn
	task automatic send_word(cache_word_t w);
		logic free;
		int gap;
		gap = 0;
		while ($urandom_range(99) < idle_pct) gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		action <= w.action;
		{key_word_0, key_word_1, key_word_2, key_word_3} <= w.key;
		payload <= w.payload;
		entry_bytes <= w.bytes;
		// busy is looked at mid-cycle, the edge after takes the word if it was low
		forever begin
			@(negedge clk);
			free = !busy;
			@(posedge clk);
			if (free) break;
		end
		sb.note_word(w);
		accepts++;
	endtask

	// pause the sender until every predicted result has come back
	task automatic drain();
		start <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [47:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		sb.set_reg(idx, value);
	endtask

	function automatic logic [47:0] rand48();
		return 48'({$urandom(), $urandom()});
	endfunction

	function automatic logic [255:0] rand_key();
		return {$urandom(), $urandom(), $urandom(), $urandom(),
			$urandom(), $urandom(), $urandom(), $urandom()};
	endfunction

	// random word: mostly keys from a small pool so hits and re-check hits are common
	function automatic cache_word_t make_word();
		cache_word_t w;
		int pick;
		logic [47:0] lim;
		lim = sb.byte_limit;
		w.action = $urandom_range(99) < 55;
		if ($urandom_range(99) < 80) begin
			w.key = key_pool[$urandom_range(23)];
		end else begin
			w.key = rand_key();
			// refresh the pool now and then so new keys keep arriving
			if ($urandom_range(3) == 0) key_pool[$urandom_range(23, 2)] = w.key;
		end
		w.payload = $urandom();
		pick = $urandom_range(99);
		if (pick < 65) begin
			// small sizes so several entries share the budget
			w.bytes = (lim == 0) ? 48'd0 : rand48() % ((lim >> 2) + 1);
		end else if (pick < 75) begin
			w.bytes = rand48();
		end else if (pick < 88) begin
			w.bytes = lim - $urandom_range(1);   // at or near the budget
			if ($urandom_range(2) == 0) w.bytes = lim + 1;
		end else begin
			w.bytes = '0;
		end
		return w;
	endfunction

	function automatic cache_word_t word(logic act, logic [255:0] k, logic [31:0] p,
			logic [47:0] b);
		cache_word_t w;
		w.action = act;
		w.key = k;
		w.payload = p;
		w.bytes = b;
		return w;
	endfunction

	// per phase: entry limit, byte budget, sender idle share
	int          ph_entries [8] = '{16, 4, 0, 31, 1, 16, 8, 8};
	logic [47:0] ph_bytes [8]   = '{BYTES_FULL, 48'd5000, 48'd5000, 48'd100000,
		48'd1, 48'd0, 48'd2000, 48'd300};
	int          ph_idle [8]    = '{0, 85, 0, 34, 85, 0, 85, 34};

	initial begin
		logic [255:0] kz, ko, ka;
		kz = '0;
		ko = '1;
		ka = rand_key();
		key_pool[0] = kz;
		key_pool[1] = ko;
		for (int i = 2; i < 24; i++) key_pool[i] = rand_key();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: miss, insert, hit, re-check hit, extremes of key, handle and size
		send_word(word(1'b0, kz, 32'h0, 48'h0));
		send_word(word(1'b1, kz, 32'h0, 48'h0));
		send_word(word(1'b0, kz, 32'h1234, 48'h5));
		send_word(word(1'b1, kz, 32'hdead, 48'h7));
		send_word(word(1'b1, ko, 32'hffff_ffff, 48'h1));
		// a size equal to the full budget pushes everything else out
		send_word(word(1'b1, ka, 32'h5a5a_a5a5, BYTES_FULL));
		send_word(word(1'b0, ko, 32'h0, 48'h0));
		send_word(word(1'b1, ka, 32'h0, 48'h0));
		send_word(word(1'b0, ka, 32'h0, BYTES_FULL));
		// fill past the entry limit so the oldest entries go
		for (int i = 0; i < 17; i++) begin
			send_word(word(1'b1, rand_key(), $urandom(), 48'(i + 1)));
		end
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			write_reg(REG_MAX_ENTRIES, 48'(ph_entries[ph]));
			write_reg(REG_MAX_BYTES, ph_bytes[ph]);
			idle_pct = ph_idle[ph];
			for (int n = 0; n < 215; n++) begin
				// a stretch with no idling inside the idle phases
				if (n == 150 && idle_pct != 0) idle_pct = 0;
				send_word(make_word());
			end
			drain();
		end

		repeat (30) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire
